// ----- hw/rtl/rcpd_pkg.sv -----
// Shared types and constants for the RC pulse direction controller.
package rcpd_pkg;

  typedef enum logic [2:0] {
    OP_RC_EDGE   = 3'd0,
    OP_TIMEBASE  = 3'd1,
    OP_CONTROL   = 3'd2,
    OP_PWM_OVF   = 3'd3,
    OP_PWM_CMP   = 3'd4
  } rcpd_op_e;

  typedef enum logic [2:0] {
    REG_PULSE_LOW    = 3'd0,
    REG_PULSE_MID    = 3'd1,
    REG_PULSE_HIGH   = 3'd2,
    REG_PULSE_MARGIN = 3'd3,
    REG_DEADZONE     = 3'd4,
    REG_PWM_DUTY     = 3'd5
  } rcpd_reg_e;

  localparam logic [1:0] DIR_UNINIT = 2'd0;
  localparam logic [1:0] DIR_FWD    = 2'd1;
  localparam logic [1:0] DIR_BWD    = 2'd2;
  localparam logic [1:0] DIR_BRAKE  = 2'd3;

  localparam logic [3:0] ARM_LIMIT      = 4'd10;
  localparam logic [3:0] ARM_RELOAD     = 4'd15;
  localparam logic [5:0] TIMEOUT_RELOAD = 6'd50;
  localparam logic [7:0] PUMP_DUTY_MIN  = 8'd250;
  localparam logic [5:0] PUMP_LIMIT     = 6'd50;
  localparam logic [7:0] DUTY_FULL      = 8'd255;

  typedef struct packed {
    logic       armed;
    logic       bwd_high_on;
    logic       fwd_high_on;
    logic [1:0] motor_dir;
    logic [1:0] requested_dir;
  } rcpd_result_t;

endpackage

// ----- hw/rtl/rc_pulse_direction_controller.sv -----
// Top level of the RC pulse direction controller: event decode, state and result register.
//
// Each transaction on the slave stream is one event (RC edge, timebase overflow, control
// tick, PWM overflow or PWM compare); the block updates its state in the cycle the event is
// accepted and presents one result transaction carrying the state after that event. All
// per-event logic sits between the state registers and a single result register, so one
// event is taken every clock cycle; s_axis_tready_o drops only while a result is held by a
// stalled master side. Configuration writes are taken every cycle (cfg_ready_o is always
// high) and must only be issued while no result is outstanding; indices above 5 are ignored.
module rc_pulse_direction_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // [0] pin_level, [8:1] counter_low, [15:9] zero
  input  logic [2:0]  s_axis_tuser_i,  // [2:0] opcode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [1:0] requested_dir, [3:2] motor_dir, [4] fwd_high_on, [5] bwd_high_on, [6] armed,
  // [7] zero
  output logic [7:0]  m_axis_tdata_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] pulse_low_q, pulse_mid_q, pulse_high_q;
  logic [7:0]  pulse_margin_q, deadzone_q, pwm_duty_q;

  logic [1:0]  applied_dir_q, applied_dir_d;
  logic [1:0]  wanted_dir_q, wanted_dir_d;
  logic [3:0]  good_count_q, good_count_d;
  logic [5:0]  timeout_q, timeout_d;
  logic [7:0]  time_high_q, time_high_d;
  logic [15:0] rise_ts_q, rise_ts_d;
  logic        tick_seen_q, tick_seen_d;
  logic [5:0]  pump_count_q, pump_count_d;
  logic        fwd_drive_q, fwd_drive_d;
  logic        bwd_drive_q, bwd_drive_d;

  logic                 out_valid_q;
  rcpd_pkg::rcpd_result_t result_q, result_d;

  logic        in_accept;
  logic        pin_level;
  logic [7:0]  counter_low;
  logic [15:0] now_ts;
  logic [15:0] width;
  logic        width_valid;
  logic        in_brake_band;
  logic [3:0]  count_dec;
  logic [5:0]  pump_inc;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  assign pin_level   = s_axis_tdata_i[0];
  assign counter_low = s_axis_tdata_i[8:1];
  assign now_ts      = {time_high_q, counter_low};
  assign width       = now_ts - rise_ts_q;

  assign width_valid =
      ((pulse_margin_q > pulse_low_q[7:0] && pulse_low_q[15:8] == 8'd0) ||
       (width > (pulse_low_q - {8'd0, pulse_margin_q}))) &&
      ({1'b0, width} < ({1'b0, pulse_high_q} + {9'd0, pulse_margin_q}));

  assign in_brake_band =
      ((deadzone_q > pulse_mid_q[7:0] && pulse_mid_q[15:8] == 8'd0) ||
       (width > (pulse_mid_q - {8'd0, deadzone_q}))) &&
      ({1'b0, width} < ({1'b0, pulse_mid_q} + {9'd0, deadzone_q}));

  assign count_dec = (good_count_q != 4'd0) ? good_count_q - 4'd1 : 4'd0;
  assign pump_inc  = pump_count_q + 6'd1;

  always_comb begin
    applied_dir_d = applied_dir_q;
    wanted_dir_d  = wanted_dir_q;
    good_count_d  = good_count_q;
    timeout_d     = timeout_q;
    time_high_d   = time_high_q;
    rise_ts_d     = rise_ts_q;
    tick_seen_d   = tick_seen_q;
    pump_count_d  = pump_count_q;
    fwd_drive_d   = fwd_drive_q;
    bwd_drive_d   = bwd_drive_q;
    case (s_axis_tuser_i)
      rcpd_pkg::OP_RC_EDGE: begin
        if (pin_level) begin
          rise_ts_d = now_ts;
        end else if (width_valid) begin
          if (good_count_q > rcpd_pkg::ARM_LIMIT) begin
            good_count_d = rcpd_pkg::ARM_RELOAD;
            timeout_d    = rcpd_pkg::TIMEOUT_RELOAD;
            if (in_brake_band) begin
              wanted_dir_d = rcpd_pkg::DIR_BRAKE;
            end else if (width < pulse_mid_q) begin
              wanted_dir_d = rcpd_pkg::DIR_BWD;
            end else begin
              wanted_dir_d = rcpd_pkg::DIR_FWD;
            end
          end else begin
            good_count_d = good_count_q + 4'd1;
          end
        end else begin
          good_count_d = count_dec;
          if (count_dec < rcpd_pkg::ARM_LIMIT) begin
            wanted_dir_d = rcpd_pkg::DIR_BRAKE;
          end
        end
      end
      rcpd_pkg::OP_TIMEBASE: begin
        if (timeout_q == 6'd0) begin
          wanted_dir_d = rcpd_pkg::DIR_BRAKE;
        end else begin
          timeout_d = timeout_q - 6'd1;
        end
        time_high_d = time_high_q + 8'd1;
        tick_seen_d = 1'b1;
      end
      rcpd_pkg::OP_CONTROL: begin
        if (tick_seen_q && applied_dir_q != wanted_dir_q) begin
          if (wanted_dir_q != rcpd_pkg::DIR_BRAKE && applied_dir_q != rcpd_pkg::DIR_BRAKE) begin
            fwd_drive_d   = 1'b0;
            bwd_drive_d   = 1'b0;
            applied_dir_d = rcpd_pkg::DIR_BRAKE;
          end else if (wanted_dir_q == rcpd_pkg::DIR_FWD) begin
            fwd_drive_d   = 1'b1;
            bwd_drive_d   = 1'b0;
            applied_dir_d = rcpd_pkg::DIR_FWD;
          end else if (wanted_dir_q == rcpd_pkg::DIR_BWD) begin
            fwd_drive_d   = 1'b0;
            bwd_drive_d   = 1'b1;
            applied_dir_d = rcpd_pkg::DIR_BWD;
          end else begin
            fwd_drive_d   = 1'b0;
            bwd_drive_d   = 1'b0;
            applied_dir_d = rcpd_pkg::DIR_BRAKE;
          end
        end
      end
      rcpd_pkg::OP_PWM_OVF: begin
        if (pwm_duty_q != 8'd0) begin
          if (applied_dir_q == rcpd_pkg::DIR_FWD) begin
            fwd_drive_d = 1'b1;
          end else if (applied_dir_q == rcpd_pkg::DIR_BWD) begin
            bwd_drive_d = 1'b1;
          end
        end
        if (pwm_duty_q > rcpd_pkg::PUMP_DUTY_MIN && applied_dir_q != rcpd_pkg::DIR_BRAKE) begin
          if (pump_inc > rcpd_pkg::PUMP_LIMIT) begin
            fwd_drive_d  = 1'b0;
            bwd_drive_d  = 1'b0;
            pump_count_d = 6'd0;
          end else begin
            pump_count_d = pump_inc;
          end
        end
      end
      rcpd_pkg::OP_PWM_CMP: begin
        if (pwm_duty_q != rcpd_pkg::DUTY_FULL && applied_dir_q != rcpd_pkg::DIR_BRAKE) begin
          fwd_drive_d = 1'b0;
          bwd_drive_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result_d.requested_dir = wanted_dir_d;
    result_d.motor_dir     = applied_dir_d;
    result_d.fwd_high_on   = fwd_drive_d;
    result_d.bwd_high_on   = bwd_drive_d;
    result_d.armed         = good_count_d > rcpd_pkg::ARM_LIMIT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_low_q    <= 16'd1000;
      pulse_mid_q    <= 16'd1500;
      pulse_high_q   <= 16'd2000;
      pulse_margin_q <= 8'd20;
      deadzone_q     <= 8'd20;
      pwm_duty_q     <= 8'd255;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rcpd_pkg::REG_PULSE_LOW:    pulse_low_q    <= cfg_data_i;
        rcpd_pkg::REG_PULSE_MID:    pulse_mid_q    <= cfg_data_i;
        rcpd_pkg::REG_PULSE_HIGH:   pulse_high_q   <= cfg_data_i;
        rcpd_pkg::REG_PULSE_MARGIN: pulse_margin_q <= cfg_data_i[7:0];
        rcpd_pkg::REG_DEADZONE:     deadzone_q     <= cfg_data_i[7:0];
        rcpd_pkg::REG_PWM_DUTY:     pwm_duty_q     <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      applied_dir_q <= rcpd_pkg::DIR_BRAKE;
      wanted_dir_q  <= rcpd_pkg::DIR_BRAKE;
      good_count_q  <= 4'd0;
      timeout_q     <= rcpd_pkg::TIMEOUT_RELOAD;
      time_high_q   <= 8'd0;
      rise_ts_q     <= 16'd0;
      tick_seen_q   <= 1'b0;
      pump_count_q  <= 6'd0;
      fwd_drive_q   <= 1'b0;
      bwd_drive_q   <= 1'b0;
    end else if (in_accept) begin
      applied_dir_q <= applied_dir_d;
      wanted_dir_q  <= wanted_dir_d;
      good_count_q  <= good_count_d;
      timeout_q     <= timeout_d;
      time_high_q   <= time_high_d;
      rise_ts_q     <= rise_ts_d;
      tick_seen_q   <= tick_seen_d;
      pump_count_q  <= pump_count_d;
      fwd_drive_q   <= fwd_drive_d;
      bwd_drive_q   <= bwd_drive_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, result_q};

  a_drives_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fwd_drive_q && bwd_drive_q))
    else $error("both high-side drives on");

  a_fwd_drive_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_drive_q |-> applied_dir_q == rcpd_pkg::DIR_FWD)
    else $error("forward drive on while not applying forward");

  a_no_direct_reversal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    applied_dir_q == rcpd_pkg::DIR_FWD |=> applied_dir_q != rcpd_pkg::DIR_BWD)
    else $error("reversal without passing through brake");

  a_pump_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pump_count_q <= rcpd_pkg::PUMP_LIMIT)
    else $error("charge-pump counter past its limit");

  a_timeout_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    timeout_q <= rcpd_pkg::TIMEOUT_RELOAD)
    else $error("signal timeout above reload value");

endmodule
